[hdl/srs_pkg.sv]
// shared constants, types and helpers of the segment range scheduler
package srs_pkg;

   localparam int MaxChannels = 16;
   localparam int ChanBits    = $clog2(MaxChannels);
   localparam int CountBits   = $clog2(MaxChannels + 1);
   localparam int OffsetBits  = 48;
   localparam int LenBits     = 21;
   localparam int ReqBits     = 7;
   localparam int ChunkBits   = 24;
   localparam int CsrBits     = 64;
   localparam int AddrBits    = 5;
   localparam int ReqDataBits = 32;
   localparam int RspDataBits = 184;
   localparam int MinChunkReset = 100 * 1024;
   localparam int ReqChanLo   = 0;
   localparam int ReqLenLo    = 6;

   typedef logic [OffsetBits-1:0] ofs_type;
   typedef logic [LenBits-1:0]    len_type;
   typedef logic [ChanBits-1:0]   idx_type;
   typedef logic [CountBits-1:0]  cnt_type;
   typedef logic [2:0]            mode_type;
   typedef logic [1:0]            reg_index_type;

   localparam mode_type MODE_DIVIDE  = 3'd0;
   localparam mode_type MODE_DATA    = 3'd1;
   localparam mode_type MODE_END     = 3'd2;
   localparam mode_type MODE_ERROR   = 3'd3;
   localparam mode_type MODE_CONNECT = 3'd4;

   localparam reg_index_type REG_TOTAL_SIZE = 2'd0;
   localparam reg_index_type REG_REQ_CHANS  = 2'd1;
   localparam reg_index_type REG_MIN_CHUNK  = 2'd2;

   typedef struct packed {
      ofs_type              total_size;
      logic [ReqBits-1:0]   requested_channels;
      logic [ChunkBits-1:0] min_chunk;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIV_MAXC, ST_WAIT_MAXC, ST_DIV_SEG, ST_WAIT_SEG, ST_DIV_TAIL,
      ST_WAIT_TAIL, ST_DIV_WRITE, ST_DIV_EMIT, ST_EVENT, ST_SCAN, ST_STEAL,
      ST_EMIT_THIEF, ST_EMIT_VICTIM
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_ACCEPT, OP_START_MAXC, OP_TAKE_MAXC, OP_START_SEG, OP_TAKE_SEG,
      OP_START_TAIL, OP_TAKE_TAIL, OP_DIV_WRITE, OP_DIV_EMIT, OP_EVENT, OP_SCAN,
      OP_STEAL, OP_EMIT_THIEF, OP_EMIT_VICTIM
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic req_divide;
      logic req_ok;
      logic div_done;
      logic out_free;
      logic loop_last;
      logic scan_last;
      logic steal_try;
      logic found;
      logic tail_needed;
   } status_type;

   function automatic ofs_type rem_of(ofs_type nb, ofs_type eb);
      rem_of = (eb > nb) ? eb - nb : '0;
   endfunction

endpackage

[hdl/srs_div.sv]
// restoring divider, one quotient bit per cycle
module srs_div (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  srs_pkg::ofs_type dividend,
   input  srs_pkg::ofs_type divisor,
   output srs_pkg::ofs_type quotient,
   output srs_pkg::ofs_type remainder,
   output logic            done
);
   import srs_pkg::*;

   localparam int StepBits = $clog2(OffsetBits);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [StepBits-1:0] step_ff, step_in;
   ofs_type             quo_ff, quo_in;
   ofs_type             rem_ff, rem_in;
   ofs_type             den_ff, den_in;
   logic [OffsetBits:0] trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      trial   = {rem_ff, quo_ff[OffsetBits-1]};
      if (start) begin
         busy_in = 1'b1;
         step_in = StepBits'(OffsetBits - 1);
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = OffsetBits'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[OffsetBits-2:0], 1'b1};
         end else begin
            rem_in = trial[OffsetBits-1:0];
            quo_in = {quo_ff[OffsetBits-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;
endmodule

[hdl/srs_csr.sv]
// configuration registers behind the apb-style port
module srs_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [srs_pkg::AddrBits-1:0]     csr_paddr,
   input  logic [srs_pkg::CsrBits-1:0]      csr_pwdata,
   output logic [srs_pkg::CsrBits-1:0]      csr_prdata,
   output logic                             csr_pready,
   output srs_pkg::cfg_type                 cfg
);
   import srs_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   reg_index_type index;
   logic          wr;

   assign index      = csr_paddr[AddrBits-1:3];
   assign csr_pready = 1'b1;
   assign wr         = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (index)
            REG_TOTAL_SIZE: cfg_in.total_size = csr_pwdata[OffsetBits-1:0];
            REG_REQ_CHANS:  cfg_in.requested_channels = csr_pwdata[ReqBits-1:0];
            REG_MIN_CHUNK:  cfg_in.min_chunk = csr_pwdata[ChunkBits-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_TOTAL_SIZE: csr_prdata = CsrBits'(cfg_ff.total_size);
         REG_REQ_CHANS:  csr_prdata = CsrBits'(cfg_ff.requested_channels);
         REG_MIN_CHUNK:  csr_prdata = CsrBits'(cfg_ff.min_chunk);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.total_size         <= '0;
         cfg_ff.requested_channels <= ReqBits'(4);
         cfg_ff.min_chunk          <= ChunkBits'(MinChunkReset);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

[hdl/srs_ctrl.sv]
// sequencer: steps the datapath through divide, event and steal
module srs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  srs_pkg::status_type status,
   output srs_pkg::cmd_type    cmd
);
   import srs_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd.op     = OP_NONE;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op = OP_ACCEPT;
               if (status.req_divide) begin
                  state_in = ST_DIV_MAXC;
               end else if (status.req_ok) begin
                  state_in = ST_EVENT;
               end
            end
         end
         ST_DIV_MAXC: begin
            cmd.op   = OP_START_MAXC;
            state_in = ST_WAIT_MAXC;
         end
         ST_WAIT_MAXC: begin
            if (status.div_done) begin
               cmd.op   = OP_TAKE_MAXC;
               state_in = ST_DIV_SEG;
            end
         end
         ST_DIV_SEG: begin
            cmd.op   = OP_START_SEG;
            state_in = ST_WAIT_SEG;
         end
         ST_WAIT_SEG: begin
            if (status.div_done) begin
               cmd.op   = OP_TAKE_SEG;
               state_in = ST_DIV_TAIL;
            end
         end
         ST_DIV_TAIL: begin
            if (status.tail_needed) begin
               cmd.op   = OP_START_TAIL;
               state_in = ST_WAIT_TAIL;
            end else begin
               cmd.op   = OP_TAKE_TAIL;
               state_in = ST_DIV_WRITE;
            end
         end
         ST_WAIT_TAIL: begin
            if (status.div_done) begin
               cmd.op   = OP_TAKE_TAIL;
               state_in = ST_DIV_WRITE;
            end
         end
         ST_DIV_WRITE: begin
            cmd.op   = OP_DIV_WRITE;
            state_in = ST_DIV_EMIT;
         end
         ST_DIV_EMIT: begin
            if (status.out_free) begin
               cmd.op   = OP_DIV_EMIT;
               state_in = status.loop_last ? ST_IDLE : ST_DIV_WRITE;
            end
         end
         ST_EVENT: begin
            cmd.op   = OP_EVENT;
            state_in = status.steal_try ? ST_SCAN : ST_EMIT_THIEF;
         end
         ST_SCAN: begin
            cmd.op = OP_SCAN;
            if (status.scan_last) begin
               state_in = ST_STEAL;
            end
         end
         ST_STEAL: begin
            if (status.found) begin
               cmd.op = OP_STEAL;
            end
            state_in = ST_EMIT_THIEF;
         end
         ST_EMIT_THIEF: begin
            if (status.out_free) begin
               cmd.op   = OP_EMIT_THIEF;
               state_in = status.found ? ST_EMIT_VICTIM : ST_IDLE;
            end
         end
         ST_EMIT_VICTIM: begin
            if (status.out_free) begin
               cmd.op   = OP_EMIT_VICTIM;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

[hdl/srs_dpath.sv]
// range table, work registers, divider and output register
module srs_dpath (
   input  logic                               clock,
   input  logic                               reset,
   input  srs_pkg::cmd_type                   cmd,
   output srs_pkg::status_type                status,
   input  srs_pkg::cfg_type                   cfg,
   input  logic [srs_pkg::ReqDataBits-1:0]    req_tdata,
   input  srs_pkg::mode_type                  req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [srs_pkg::RspDataBits-1:0]    rsp_tdata,
   output logic                               rsp_tlast
);
   import srs_pkg::*;

   ofs_type nb_ff [MaxChannels];
   ofs_type nb_in [MaxChannels];
   ofs_type eb_ff [MaxChannels];
   ofs_type eb_in [MaxChannels];
   logic [MaxChannels-1:0] en_ff, en_in;
   ofs_type done_ff, done_in;
   cnt_type count_ff, count_in;

   mode_type mode_ff, mode_in;
   idx_type  chan_ff, chan_in;
   len_type  dlen_ff, dlen_in;
   cnt_type  cnt_ff, cnt_in;
   ofs_type  seg_ff, seg_in;
   ofs_type  tail_ff, tail_in;
   ofs_type  acc_ff, acc_in;
   idx_type  idx_ff, idx_in;
   ofs_type  best_ff, best_in;
   idx_type  victim_ff, victim_in;
   logic     found_ff, found_in;
   logic     try_ff, try_in;
   ofs_type  wo_ff, wo_in;
   len_type  wl_ff, wl_in;
   logic     closed_ff, closed_in;

   logic                   out_valid_ff, out_valid_in;
   logic [RspDataBits-1:0] out_data_ff, out_data_in;
   logic                   out_last_ff, out_last_in;

   logic    div_start, div_done;
   ofs_type div_divisor, div_quo, div_rem;

   idx_type              ra;
   ofs_type              rd_nb, rd_eb, rd_rem, nb_new, maxc1;
   logic [ChunkBits-1:0] minc_eff;
   cnt_type              reqc, cnt_calc;
   logic                 out_free, over;
   logic [ChanBits:0]    chan_req_w;

   srs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (cfg.total_size),
      .divisor   (div_divisor),
      .quotient  (div_quo),
      .remainder (div_rem),
      .done      (div_done)
   );

   assign minc_eff = (cfg.min_chunk == '0) ? ChunkBits'(1) : cfg.min_chunk;
   assign out_free = !out_valid_ff || rsp_tready;

   // requested count clamped to 1..max channels
   always_comb begin
      if (cfg.requested_channels == '0) begin
         reqc = CountBits'(1);
      end else if (cfg.requested_channels > ReqBits'(MaxChannels)) begin
         reqc = CountBits'(MaxChannels);
      end else begin
         reqc = CountBits'(cfg.requested_channels);
      end
      maxc1    = (div_quo == '0) ? OffsetBits'(1) : div_quo;
      cnt_calc = (OffsetBits'(reqc) < maxc1) ? reqc : CountBits'(maxc1);
   end

   always_comb begin
      unique case (cmd.op)
         OP_DIV_EMIT, OP_SCAN:       ra = idx_ff;
         OP_STEAL, OP_EMIT_VICTIM:   ra = victim_ff;
         default:                    ra = chan_ff;
      endcase
   end

   assign rd_nb  = nb_ff[ra];
   assign rd_eb  = eb_ff[ra];
   assign rd_rem = rem_of(rd_nb, rd_eb);
   assign over   = OffsetBits'(dlen_ff) > rd_rem;
   assign nb_new = rd_nb + (over ? rd_rem : OffsetBits'(dlen_ff));

   assign chan_req_w = (ChanBits+1)'(req_tdata[ReqChanLo +: 6]);

   always_comb begin
      status.req_divide  = (req_tuser == MODE_DIVIDE);
      status.req_ok      = ((req_tuser == MODE_DATA) || (req_tuser == MODE_END) ||
                            (req_tuser == MODE_ERROR) || (req_tuser == MODE_CONNECT)) &&
                           (req_tdata[ReqChanLo +: 6] < 6'(count_ff));
      status.div_done    = div_done;
      status.out_free    = out_free;
      status.loop_last   = (CountBits'(idx_ff) == count_ff - 1'b1);
      status.scan_last   = (CountBits'(idx_ff) == count_ff - 1'b1);
      status.steal_try   = try_in;
      status.found       = found_ff;
      status.tail_needed = (seg_ff != '0);
   end

   always_comb begin
      nb_in = nb_ff;
      eb_in = eb_ff;
      en_in = en_ff;
      done_in = done_ff;
      count_in = count_ff;
      mode_in = mode_ff;
      chan_in = chan_ff;
      dlen_in = dlen_ff;
      cnt_in = cnt_ff;
      seg_in = seg_ff;
      tail_in = tail_ff;
      acc_in = acc_ff;
      idx_in = idx_ff;
      best_in = best_ff;
      victim_in = victim_ff;
      found_in = found_ff;
      try_in = try_ff;
      wo_in = wo_ff;
      wl_in = wl_ff;
      closed_in = closed_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in = out_data_ff;
      out_last_in = out_last_ff;
      div_start = 1'b0;
      div_divisor = '0;
      unique case (cmd.op)
         OP_ACCEPT: begin
            mode_in = req_tuser;
            chan_in = chan_req_w[ChanBits-1:0];
            dlen_in = req_tdata[ReqLenLo +: LenBits];
         end
         OP_START_MAXC: begin
            div_start   = 1'b1;
            div_divisor = OffsetBits'(minc_eff);
         end
         OP_TAKE_MAXC: cnt_in = cnt_calc;
         OP_START_SEG: begin
            div_start   = 1'b1;
            div_divisor = OffsetBits'(cnt_ff);
         end
         OP_TAKE_SEG: begin
            if (div_quo == '0) begin
               count_in = CountBits'(1);
               seg_in   = cfg.total_size;
            end else begin
               count_in = cnt_ff;
               seg_in   = div_quo;
            end
         end
         OP_START_TAIL: begin
            div_start   = 1'b1;
            div_divisor = seg_ff;
         end
         OP_TAKE_TAIL: begin
            tail_in = (seg_ff == '0) ? '0 : div_rem;
            acc_in  = '0;
            idx_in  = '0;
         end
         OP_DIV_WRITE: begin
            nb_in[idx_ff] = acc_ff;
            eb_in[idx_ff] = acc_ff + seg_ff +
                            ((CountBits'(idx_ff) == count_ff - 1'b1) ? tail_ff : '0);
         end
         OP_DIV_EMIT: begin
            out_valid_in = 1'b1;
            out_last_in  = (CountBits'(idx_ff) == count_ff - 1'b1);
            out_data_in  = {3'b000, (done_ff == cfg.total_size), 7'(count_ff), 1'b0, 1'b0,
                            {LenBits{1'b0}}, {OffsetBits{1'b0}}, rd_eb, rd_nb, 6'(idx_ff)};
            acc_in = acc_ff + seg_ff;
            idx_in = idx_ff + 1'b1;
         end
         OP_EVENT: begin
            wo_in     = '0;
            wl_in     = '0;
            closed_in = 1'b0;
            try_in    = 1'b0;
            found_in  = 1'b0;
            idx_in    = '0;
            best_in   = OffsetBits'(minc_eff - 1'b1);
            unique case (mode_ff)
               MODE_DATA: begin
                  wo_in = rd_nb;
                  if (en_ff[chan_ff]) begin
                     wl_in          = over ? LenBits'(rd_rem) : dlen_ff;
                     nb_in[chan_ff] = nb_new;
                     done_in        = done_ff + (over ? rd_rem : OffsetBits'(dlen_ff));
                     // an overrun closes the channel and always leaves it drained
                     if (over) begin
                        en_in[chan_ff] = 1'b0;
                        closed_in      = 1'b1;
                        try_in         = 1'b1;
                     end
                  end
               end
               MODE_END, MODE_ERROR: begin
                  if (en_ff[chan_ff]) begin
                     en_in[chan_ff] = 1'b0;
                     closed_in      = 1'b1;
                     try_in         = (mode_ff == MODE_END) && (rd_nb >= rd_eb);
                  end
               end
               default: en_in[chan_ff] = 1'b1;
            endcase
         end
         OP_SCAN: begin
            if (rd_rem > best_ff) begin
               best_in   = rd_rem;
               victim_in = idx_ff;
               found_in  = 1'b1;
            end
            idx_in = idx_ff + 1'b1;
         end
         OP_STEAL: begin
            eb_in[chan_ff]   = rd_eb;
            eb_in[victim_ff] = rd_nb + (best_ff >> 1);
            nb_in[chan_ff]   = rd_nb + (best_ff >> 1);
         end
         OP_EMIT_THIEF: begin
            out_valid_in = 1'b1;
            out_last_in  = !found_ff;
            out_data_in  = {3'b000, (done_ff == cfg.total_size), 7'(count_ff), found_ff,
                            closed_ff, wl_ff, wo_ff, rd_eb, rd_nb, 6'(chan_ff)};
         end
         OP_EMIT_VICTIM: begin
            out_valid_in = 1'b1;
            out_last_in  = 1'b1;
            out_data_in  = {3'b000, (done_ff == cfg.total_size), 7'(count_ff), 1'b0, 1'b0,
                            {LenBits{1'b0}}, {OffsetBits{1'b0}}, rd_eb, rd_nb, 6'(victim_ff)};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MaxChannels; i++) begin
            nb_ff[i] <= '0;
            eb_ff[i] <= '0;
         end
         en_ff        <= '0;
         done_ff      <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         try_ff       <= 1'b0;
      end else begin
         nb_ff        <= nb_in;
         eb_ff        <= eb_in;
         en_ff        <= en_in;
         done_ff      <= done_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
         found_ff     <= found_in;
         try_ff       <= try_in;
      end
      mode_ff     <= mode_in;
      chan_ff     <= chan_in;
      dlen_ff     <= dlen_in;
      cnt_ff      <= cnt_in;
      seg_ff      <= seg_in;
      tail_ff     <= tail_in;
      acc_ff      <= acc_in;
      idx_ff      <= idx_in;
      best_ff     <= best_in;
      victim_ff   <= victim_in;
      wo_ff       <= wo_in;
      wl_ff       <= wl_in;
      closed_ff   <= closed_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
endmodule

[hdl/segment_range_scheduler_unit.sv]
// top level of the segment range scheduler
//
// channel  direction  handshake               payload
// req      in         req_tvalid/req_tready   tdata channel,data_length; tuser mode
// rsp      out        rsp_tvalid/rsp_tready   tdata range word fields; tlast last
// csr      in         apb psel/penable        64-bit registers at 0, 8, 16
//
// an event word runs the event step and emits its range; with a steal scan it also
// scans each active channel and tries a steal, and one more word is emitted when a
// victim range is reported; a divide word runs three passes of the 48-bit divider
// (a zero total skips the third) and then writes and emits each channel range
// reset is synchronous and clears the range table, counters and output register
// a new word is taken whenever the sequencer is idle, even with a result still
// waiting in the output register; a stalled rsp side holds the sequencer
module segment_range_scheduler_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [srs_pkg::ReqDataBits-1:0]  req_tdata,  // channel[5:0], data_length[26:6]
   input  logic [2:0]                       req_tuser,  // mode[2:0]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // out_channel[5:0], range_start[53:6], range_end[101:54], write_offset[149:102],
   // write_length[170:150], closed[171], reassigned[172], active_count[179:173],
   // all_done[180]
   output logic [srs_pkg::RspDataBits-1:0]  rsp_tdata,
   output logic                             rsp_tlast,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [srs_pkg::AddrBits-1:0]     csr_paddr,
   input  logic [srs_pkg::CsrBits-1:0]      csr_pwdata,
   output logic [srs_pkg::CsrBits-1:0]      csr_prdata,
   output logic                             csr_pready
);
   import srs_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   srs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   srs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   srs_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .cfg        (cfg),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );
endmodule

[tb/tb_segment_range_scheduler_unit.sv]
// testbench of the segment range scheduler: scoreboard class, stream drivers and checks
module tb_segment_range_scheduler_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import srs_pkg::*;

   typedef struct packed {
      logic               last;
      logic               all_done;
      logic [ReqBits-1:0] active_count;
      logic               reassigned;
      logic               closed;
      len_type            write_length;
      ofs_type            write_offset;
      ofs_type            range_end;
      ofs_type            range_start;
      logic [5:0]         out_channel;
   } range_word_type;

   class range_scoreboard;
      ofs_type            next_ofs[MaxChannels];
      ofs_type            end_ofs[MaxChannels];
      bit                 enabled[MaxChannels];
      ofs_type            done_total;
      int unsigned        active;
      ofs_type            total;
      logic [ReqBits-1:0] req_chans;
      logic [ChunkBits-1:0] chunk;
      range_word_type     expected_q[$];
      int                 errors;
      int                 checked;
      int                 words_in;

      function new();
         for (int i = 0; i < MaxChannels; i++) begin
            next_ofs[i] = '0;
            end_ofs[i] = '0;
            enabled[i] = 0;
         end
         done_total = '0;
         active = 0;
         total = '0;
         req_chans = 7'd4;
         chunk = ChunkBits'(MinChunkReset);
         errors = 0;
         checked = 0;
         words_in = 0;
      endfunction

      function void write_reg(reg_index_type idx, longint unsigned value);
         case (idx)
            REG_TOTAL_SIZE: total = value[OffsetBits-1:0];
            REG_REQ_CHANS:  req_chans = value[ReqBits-1:0];
            REG_MIN_CHUNK:  chunk = value[ChunkBits-1:0];
            default: ;
         endcase
      endfunction

      function longint unsigned remaining(int c);
         return (end_ofs[c] > next_ofs[c]) ? end_ofs[c] - next_ofs[c] : 0;
      endfunction

      function void push_range(int c, ofs_type wo, len_type wl, bit cl, bit ra);
         range_word_type w;
         w.last = 0;
         w.all_done = (done_total == total);
         w.active_count = active[ReqBits-1:0];
         w.reassigned = ra;
         w.closed = cl;
         w.write_length = wl;
         w.write_offset = wo;
         w.range_end = end_ofs[c];
         w.range_start = next_ofs[c];
         w.out_channel = c[5:0];
         expected_q.push_back(w);
      endfunction

      // hand half of the busiest remainder to idle channel t
      function int steal_for(int t);
         longint unsigned mc, best, r;
         int victim;
         mc = (chunk != 0) ? chunk : 1;
         best = mc - 1;
         victim = -1;
         if (enabled[t] || next_ofs[t] < end_ofs[t]) return -1;
         for (int j = 0; j < active && j < MaxChannels; j++) begin
            r = remaining(j);
            if (r > best) begin
               best = r;
               victim = j;
            end
         end
         if (victim < 0) return -1;
         end_ofs[t] = end_ofs[victim];
         end_ofs[victim] = OffsetBits'(next_ofs[victim] + best / 2);
         next_ofs[t] = end_ofs[victim];
         return victim;
      endfunction

      function void note_word(mode_type mode, logic [5:0] chan, len_type len);
         longint unsigned mc, rq, maxc, cnt, seg, tail, r;
         int c, victim;
         bit cl;
         ofs_type wo;
         len_type wl;
         words_in++;
         c = int'(chan);
         victim = -1;
         cl = 0;
         wo = '0;
         wl = '0;
         if (mode == MODE_DIVIDE) begin
            mc = (chunk != 0) ? chunk : 1;
            rq = (req_chans != 0) ? req_chans : 1;
            if (rq > MaxChannels) rq = MaxChannels;
            maxc = total / mc;
            if (maxc < 1) maxc = 1;
            cnt = (rq < maxc) ? rq : maxc;
            seg = total / cnt;
            if (seg == 0) begin
               cnt = 1;
               seg = total;
            end
            active = 32'(cnt);
            for (int i = 0; i < cnt; i++) begin
               next_ofs[i] = OffsetBits'(seg * i);
               end_ofs[i] = OffsetBits'(seg * i + seg);
            end
            tail = (seg != 0) ? total % seg : 0;
            end_ofs[cnt-1] = OffsetBits'(end_ofs[cnt-1] + tail);
            for (int i = 0; i < cnt; i++) push_range(i, '0, '0, 0, 0);
         end else if (mode <= MODE_CONNECT) begin
            if (c >= active || c >= MaxChannels) return;
            if (mode == MODE_DATA) begin
               wo = next_ofs[c];
               if (enabled[c]) begin
                  r = remaining(c);
                  wl = len;
                  if (r < len) begin
                     enabled[c] = 0;
                     cl = 1;
                     wl = r[LenBits-1:0];
                  end
                  next_ofs[c] = next_ofs[c] + wl;
                  done_total = done_total + wl;
                  if (r == wl) victim = steal_for(c);
               end
            end else if (mode == MODE_END || mode == MODE_ERROR) begin
               if (enabled[c]) begin
                  enabled[c] = 0;
                  cl = 1;
                  if (mode == MODE_END) victim = steal_for(c);
               end
            end else begin
               enabled[c] = 1;
            end
            push_range(c, wo, wl, cl, victim >= 0);
            if (victim >= 0) push_range(victim, '0, '0, 0, 0);
         end else begin
            return;
         end
         expected_q[expected_q.size()-1].last = 1;
      endfunction

      function void compare_field(string name, longint unsigned e, longint unsigned a);
         if (e != a) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $realtime, name, e, a);
         end
      endfunction

      function void check_word(range_word_type act);
         range_word_type e;
         checked++;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t ns: unexpected result word, expected none, actual %h",
                     $realtime, act);
            return;
         end
         e = expected_q.pop_front();
         compare_field("out_channel", e.out_channel, act.out_channel);
         compare_field("range_start", e.range_start, act.range_start);
         compare_field("range_end", e.range_end, act.range_end);
         compare_field("write_offset", e.write_offset, act.write_offset);
         compare_field("write_length", e.write_length, act.write_length);
         compare_field("closed", e.closed, act.closed);
         compare_field("reassigned", e.reassigned, act.reassigned);
         compare_field("active_count", e.active_count, act.active_count);
         compare_field("all_done", e.all_done, act.all_done);
         compare_field("last", e.last, act.last);
      endfunction
   endclass

   localparam int CycleLimit = 800000;
   localparam int SettleCycles = 60;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [ReqDataBits-1:0] req_tdata;   // channel[5:0], data_length[26:6]
   logic [2:0]             req_tuser;   // mode[2:0]
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   // out_channel, range_start, range_end, write_offset, write_length, closed,
   // reassigned, active_count, all_done from bit 0 up
   logic [RspDataBits-1:0] rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [AddrBits-1:0]    csr_paddr;
   logic [CsrBits-1:0]     csr_pwdata;
   logic [CsrBits-1:0]     csr_prdata;
   logic                   csr_pready;

   range_scoreboard ranges = new();
   int idle_pct;
   int stall_pct;
   int cycles;
   int divides;
   int steals;

   segment_range_scheduler_unit dut (.*);

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rsp_tdata[172]) steals <= steals + 1;
         ranges.check_word({rsp_tlast, rsp_tdata[180:0]});
      end
   end

   task automatic send_word(mode_type mode, int chan, int len);
      if ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {5'b00000, len[LenBits-1:0], chan[5:0]};
      do @(posedge clock); while (!req_tready);
      ranges.note_word(mode, chan[5:0], len[LenBits-1:0]);
      if (mode == MODE_DIVIDE) divides++;
   endtask

   // sender holds off until every expected word is back, then lets the block settle
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (ranges.expected_q.size() != 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic csr_write(reg_index_type idx, longint unsigned value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      ranges.write_reg(idx, value);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(longint unsigned total, int req, int chunk);
      drain();
      csr_write(REG_TOTAL_SIZE, total);
      csr_write(REG_REQ_CHANS, req);
      csr_write(REG_MIN_CHUNK, chunk);
   endtask

   // data length aimed at the range remainder: exact, under, over, or extreme
   function automatic int pick_length(int c);
      longint unsigned r;
      int sel;
      r = (c < MaxChannels) ? ranges.remaining(c) : 0;
      if (r > 1048576) r = 1048576;
      sel = $urandom_range(9);
      case (sel)
         0: return 0;
         1: return 1048576;
         2, 3: return int'(r);
         4: return (r < 1048576) ?
                   int'(r) + int'($urandom_range(1, 1048576 - int'(r))) : int'(r);
         default: return (r > 0) ? int'($urandom_range(0, int'(r))) :
                                   int'($urandom_range(0, 1048576));
      endcase
   endfunction

   task automatic run_phase(longint unsigned total, int req, int chunk, int n,
                            int idle, int stall, bit pause_mid);
      int c, roll;
      configure(total, req, chunk);
      idle_pct = idle;
      stall_pct = stall;
      send_word(MODE_DIVIDE, $urandom_range(63), $urandom_range(1048576));
      for (int i = 0; i < ranges.active; i++) send_word(MODE_CONNECT, i, 0);
      for (int k = 0; k < n; k++) begin
         if (pause_mid && k == n / 2) drain();
         c = $urandom_range(ranges.active - 1);
         roll = $urandom_range(99);
         if (roll < 55) send_word(MODE_DATA, c, pick_length(c));
         else if (roll < 67) send_word(MODE_END, c, $urandom_range(1048576));
         else if (roll < 73) send_word(MODE_ERROR, c, 0);
         else if (roll < 88) send_word(MODE_CONNECT, c, 0);
         else if (roll < 92) begin
            send_word(MODE_DIVIDE, 0, 0);
         end else if (roll < 97) begin
            send_word(mode_type'($urandom_range(1, 4)), $urandom_range(ranges.active, 63),
                      $urandom_range(1048576));
         end else begin
            // undefined modes must be swallowed without a result
            send_word(mode_type'($urandom_range(5, 7)), c, $urandom_range(1048576));
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = MODE_DIVIDE;
      rsp_tready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      idle_pct = 0;
      stall_pct = 0;
      cycles = 0;
      divides = 0;
      steals = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: defaults with zero total, disabled channel, out of range
      send_word(MODE_DATA, 0, 5);
      send_word(MODE_DIVIDE, 63, 1048576);
      send_word(MODE_DATA, 0, 7);
      send_word(MODE_CONNECT, 0, 0);
      send_word(MODE_DATA, 0, 0);
      send_word(MODE_DATA, 0, 1048576);
      send_word(MODE_CONNECT, 63, 0);
      send_word(MODE_END, 1, 0);
      // zero request and zero chunk at the largest total
      configure(48'hFFFF_FFFF_FFFF, 0, 0);
      send_word(MODE_DIVIDE, 0, 0);
      send_word(MODE_CONNECT, 0, 0);
      send_word(MODE_DATA, 0, 1048576);
      send_word(MODE_ERROR, 0, 0);
      send_word(MODE_ERROR, 0, 0);
      // saturated request, biggest chunk
      configure(48'hFFFF_FFFF_FFFF, 64, 24'hFF_FFFF);
      send_word(MODE_DIVIDE, 0, 0);
      send_word(MODE_CONNECT, 15, 0);
      send_word(MODE_DATA, 15, 1048575);
      send_word(MODE_END, 15, 0);
      send_word(MODE_DATA, 16, 3);
      // tiny ranges so a stream end steals from a neighbor
      configure(40, 4, 2);
      send_word(MODE_DIVIDE, 0, 0);
      send_word(MODE_CONNECT, 0, 0);
      send_word(MODE_DATA, 0, 10);
      send_word(MODE_END, 0, 0);
      send_word(MODE_CONNECT, 3, 0);
      send_word(MODE_DATA, 3, 40);

      run_phase(4000000, 8, 4096, 55, 0, 0, 0);
      run_phase(10000000, 16, 65536, 50, 59, 0, 1);
      run_phase(3000001, 3, 102400, 65, 0, 59, 0);
      run_phase(48'hFFFF_FFFF_FFFF, 64, 24'hFF_FFFF, 50, 27, 27, 0);
      run_phase(900000, 64, 1, 50, 27, 27, 0);
      run_phase(5000, 1, 24'hFF_FFFF, 50, 0, 0, 0);

      drain();
      $display("sent %0d words with %0d divides; checked %0d result words, %0d steals",
               ranges.words_in, divides, ranges.checked, steals);
      $display("covered idle and stall mixes, zero and full totals, saturated requests");
      if (ranges.errors == 0 && ranges.expected_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule

[segment_range_scheduler_unit.f]
hdl/srs_pkg.sv
hdl/srs_div.sv
hdl/srs_csr.sv
hdl/srs_ctrl.sv
hdl/srs_dpath.sv
hdl/segment_range_scheduler_unit.sv
tb/tb_segment_range_scheduler_unit.sv
